/* rtl/core/assert_macros.svh */
// Assertion helpers for the tokenizer RTL.
// Both macros expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a condition holds at every clock edge outside reset.
`define JST_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("invariant violated");

// Check that a condition holds in the cycle after a trigger.
`define JST_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("sequence check violated");

`else

`define JST_ASSERT_ALWAYS(lbl, cond)
`define JST_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

/* rtl/core/jst_pkg.sv */
package jst_pkg;

	localparam int TEXT_BYTES  = 64;
	localparam int STACK_DEPTH = 16;

	localparam int TXT_W     = 7;
	localparam int SP_W      = 5;
	localparam int DEP_W     = 5;
	localparam int STK_IDX_W = $clog2(STACK_DEPTH);

	localparam logic [SP_W-1:0]  SP_LIMIT  = SP_W'(STACK_DEPTH - 1);
	localparam logic [DEP_W-1:0] DEP_LIMIT = DEP_W'(STACK_DEPTH - 1);
	localparam logic [TXT_W-1:0] TXT_LIMIT = TXT_W'(TEXT_BYTES);

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_QUOTE  = 8'h22;

	typedef enum logic [3:0] {
		ST_CONSUME      = 4'd0,
		ST_OBJ_START    = 4'd1,
		ST_LABEL        = 4'd2,
		ST_SEP          = 4'd3,
		ST_VAL_START    = 4'd4,
		ST_VALUE        = 4'd5,
		ST_VAL_STRING   = 4'd6,
		ST_END_ARR_NEXT = 4'd7,
		ST_END_NEXT     = 4'd8
	} scan_state_t;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_SYNTAX   = 3'd1,
		ERR_OBJ_FULL = 3'd2,
		ERR_ARR_FULL = 3'd3,
		ERR_UNDER    = 3'd4,
		ERR_TEXT     = 3'd5
	} err_code_t;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_LABEL = 2'd1,
		KIND_VALUE = 2'd2
	} char_kind_t;

	typedef struct packed {
		scan_state_t       st;
		logic              am;
		logic [SP_W-1:0]   sp;
		logic [DEP_W-1:0]  depth;
		logic [TXT_W-1:0]  tlen;
		err_code_t         err;
	} jst_state_t;

	typedef struct packed {
		char_kind_t        kind;
		logic [7:0]        chr;
		logic [TXT_W-1:0]  idx;
		logic              commit;
		logic              oopen;
		logic              aopen;
		logic              closed;
		logic              pushed;
		logic [DEP_W-1:0]  depth;
		err_code_t         err;
		logic              done;
	} jst_result_t;

	localparam jst_state_t JST_RESET = '{
		st:    ST_CONSUME,
		am:    1'b0,
		sp:    '0,
		depth: DEP_W'(1),
		tlen:  '0,
		err:   ERR_NONE
	};

endpackage

/* rtl/core/jst_step.sv */
module jst_step
	import jst_pkg::*;
(
	input  jst_state_t  cur,
	input  logic        cmd,
	input  logic [7:0]  in_byte,
	input  logic        pop_mode,
	output jst_state_t  nxt,
	output logic        push_en,
	output logic        push_val,
	output jst_result_t res
);

	logic        doc_end;
	logic        ws;
	logic        sp_full;
	logic        dep_full;
	logic        txt_full;
	logic        under;
	logic        am_pop;
	logic        go;

	err_code_t   err_c;
	scan_state_t nst;
	logic        p_en;
	logic        p_val;
	logic        pop;
	logic        d_inc;
	logic        d_dec;
	logic        t_clr;
	logic        t_inc;
	char_kind_t  kind_c;
	logic        commit_c;
	logic        oopen_c;
	logic        aopen_c;
	logic        closed_c;
	logic        pushed_c;

	assign doc_end  = cmd || (in_byte == 8'h00) || in_byte[7];
	assign ws       = in_byte inside {[8'h09:8'h0D], 8'h20};
	assign sp_full  = cur.sp >= SP_LIMIT;
	assign dep_full = cur.depth >= DEP_LIMIT;
	assign txt_full = cur.tlen >= TXT_LIMIT;
	assign under    = (cur.sp == '0) || (cur.depth == '0);
	// array mode as it stands after a pop; the bottom level keeps the old bit
	assign am_pop   = (cur.sp > SP_W'(1)) ? pop_mode : cur.am;
	assign go       = !doc_end && (cur.err == ERR_NONE) && (err_c == ERR_NONE);

	// decode the byte against the scan state
	always_comb begin
		err_c    = ERR_NONE;
		nst      = cur.st;
		p_en     = 1'b0;
		p_val    = 1'b0;
		pop      = 1'b0;
		d_inc    = 1'b0;
		d_dec    = 1'b0;
		t_clr    = 1'b0;
		t_inc    = 1'b0;
		kind_c   = KIND_NONE;
		commit_c = 1'b0;
		oopen_c  = 1'b0;
		aopen_c  = 1'b0;
		closed_c = 1'b0;
		pushed_c = 1'b0;
		case (cur.st)
			ST_CONSUME: begin
				if (in_byte == CH_LBRACE) begin
					if (sp_full) begin
						err_c = ERR_ARR_FULL;
					end else begin
						p_en = 1'b1;
						nst  = ST_OBJ_START;
					end
				end
			end
			ST_OBJ_START: begin
				if (in_byte == CH_QUOTE) begin
					t_clr = 1'b1;
					nst   = ST_LABEL;
				end else if (!ws) begin
					err_c = ERR_SYNTAX;
				end
			end
			ST_LABEL: begin
				if (in_byte == CH_QUOTE) begin
					nst = ST_SEP;
				end else if (txt_full) begin
					err_c = ERR_TEXT;
				end else begin
					kind_c = KIND_LABEL;
					t_inc  = 1'b1;
				end
			end
			ST_SEP: begin
				if (in_byte == CH_COLON) begin
					t_clr = 1'b1;
					nst   = ST_VAL_START;
				end else if (!ws) begin
					err_c = ERR_SYNTAX;
				end
			end
			ST_VAL_START: begin
				if (in_byte == CH_QUOTE) begin
					nst = ST_VAL_STRING;
				end else if (in_byte == CH_LBRACE) begin
					if (!cur.am && dep_full) begin
						err_c = ERR_OBJ_FULL;
					end else if (sp_full) begin
						err_c = ERR_ARR_FULL;
					end else begin
						d_inc   = !cur.am;
						oopen_c = !cur.am;
						p_en    = 1'b1;
						nst     = ST_OBJ_START;
					end
				end else if (in_byte == CH_LBRACK) begin
					if (dep_full) begin
						err_c = ERR_OBJ_FULL;
					end else if (sp_full) begin
						err_c = ERR_ARR_FULL;
					end else begin
						d_inc   = 1'b1;
						p_en    = 1'b1;
						p_val   = 1'b1;
						aopen_c = 1'b1;
					end
				end else if (!ws) begin
					if (txt_full) begin
						err_c = ERR_TEXT;
					end else begin
						kind_c = KIND_VALUE;
						t_inc  = 1'b1;
						nst    = ST_VALUE;
					end
				end
			end
			ST_VALUE: begin
				if ((in_byte inside {CH_COMMA, CH_RBRACK, CH_RBRACE}) || ws) begin
					if ((in_byte inside {CH_RBRACK, CH_RBRACE}) && under) begin
						err_c = ERR_UNDER;
					end else begin
						commit_c = 1'b1;
						t_clr    = 1'b1;
						if (in_byte == CH_COMMA) begin
							nst = cur.am ? ST_VAL_START : ST_OBJ_START;
						end else if (in_byte == CH_RBRACK) begin
							pop      = 1'b1;
							d_dec    = 1'b1;
							closed_c = 1'b1;
							nst      = ST_END_NEXT;
						end else if (in_byte == CH_RBRACE) begin
							pop      = 1'b1;
							d_dec    = 1'b1;
							closed_c = 1'b1;
							nst      = ST_END_ARR_NEXT;
						end else begin
							nst = ST_END_NEXT;
						end
					end
				end else if (txt_full) begin
					err_c = ERR_TEXT;
				end else begin
					kind_c = KIND_VALUE;
					t_inc  = 1'b1;
				end
			end
			ST_VAL_STRING: begin
				if (in_byte == CH_QUOTE) begin
					commit_c = 1'b1;
					t_clr    = 1'b1;
					nst      = ST_END_NEXT;
				end else if (txt_full) begin
					err_c = ERR_TEXT;
				end else begin
					kind_c = KIND_VALUE;
					t_inc  = 1'b1;
				end
			end
			ST_END_ARR_NEXT: begin
				if (in_byte == CH_COMMA) begin
					if (dep_full) begin
						err_c = ERR_OBJ_FULL;
					end else begin
						pushed_c = 1'b1;
						d_inc    = 1'b1;
						oopen_c  = 1'b1;
						nst      = ST_VAL_START;
					end
				end else if (in_byte == CH_RBRACK) begin
					if (under) begin
						err_c = ERR_UNDER;
					end else begin
						d_dec    = 1'b1;
						pop      = 1'b1;
						closed_c = 1'b1;
						pushed_c = 1'b1;
						nst      = ST_CONSUME;
					end
				end else if (!ws) begin
					err_c = ERR_SYNTAX;
				end
			end
			ST_END_NEXT: begin
				if (in_byte == CH_COMMA) begin
					nst = ST_OBJ_START;
				end else if (in_byte == CH_RBRACE) begin
					if (under) begin
						err_c = ERR_UNDER;
					end else begin
						d_dec    = 1'b1;
						pop      = 1'b1;
						closed_c = 1'b1;
						nst      = am_pop ? ST_END_ARR_NEXT : ST_CONSUME;
					end
				end else if (!ws) begin
					err_c = ERR_SYNTAX;
				end
			end
			default: begin
				nst = ST_CONSUME;
			end
		endcase
	end

	// next state: reset on document end, hold after an error
	always_comb begin
		nxt = cur;
		if (doc_end) begin
			nxt = JST_RESET;
		end else if (cur.err != ERR_NONE) begin
			nxt = cur;
		end else if (err_c != ERR_NONE) begin
			nxt.err = err_c;
		end else begin
			nxt.st = nst;
			if (p_en) begin
				nxt.am = p_val;
				nxt.sp = cur.sp + SP_W'(1);
			end
			if (pop) begin
				nxt.am = am_pop;
				nxt.sp = cur.sp - SP_W'(1);
			end
			if (d_inc) begin
				nxt.depth = cur.depth + DEP_W'(1);
			end
			if (d_dec) begin
				nxt.depth = cur.depth - DEP_W'(1);
			end
			if (t_clr) begin
				nxt.tlen = '0;
			end
			if (t_inc) begin
				nxt.tlen = cur.tlen + TXT_W'(1);
			end
		end
	end

	assign push_en  = go && p_en;
	assign push_val = p_val;

	// result item
	always_comb begin
		res       = '0;
		res.depth = nxt.depth;
		if (doc_end) begin
			res.done  = 1'b1;
			res.err   = cur.err;
			res.depth = cur.depth;
		end else if (cur.err != ERR_NONE) begin
			res.err = cur.err;
		end else if (err_c != ERR_NONE) begin
			res.err = err_c;
		end else begin
			res.kind   = kind_c;
			res.chr    = (kind_c != KIND_NONE) ? in_byte : 8'h00;
			res.idx    = ((kind_c != KIND_NONE) || commit_c) ? cur.tlen : '0;
			res.commit = commit_c;
			res.oopen  = oopen_c;
			res.aopen  = aopen_c;
			res.closed = closed_c;
			res.pushed = pushed_c;
		end
	end

endmodule

/* rtl/core/json_stream_tokenizer_unit.sv */
// Path: each accepted request passes the input register, then the result register.
// Throughput: one byte per cycle while out_ready holds; the scanner state, depth count and one-bit
// array-mode stack update together from each byte, so bytes follow back to back.
// Reset: arst_n clears scanner state, counters, latched error and the valid flags at once;
// the array-mode stack bits are not reset, since each is written before it is read.
`include "assert_macros.svh"

module json_stream_tokenizer_unit
	import jst_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,

	input  logic              in_valid,
	output logic              in_ready,
	input  logic              cmd,
	input  logic [7:0]        in_byte,

	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        char_kind,
	output logic [7:0]        char_out,
	output logic [TXT_W-1:0]  char_index,
	output logic              value_commit,
	output logic              object_opened,
	output logic              array_opened,
	output logic              level_closed,
	output logic              item_pushed,
	output logic [DEP_W-1:0]  nest_depth,
	output logic [2:0]        error_code,
	output logic              doc_done
);

	// input stage: one request held ahead of the scanner
	logic        valid_s1;
	logic        cmd_s1;
	logic [7:0]  byte_s1;

	// scanner state and the array-mode stack
	jst_state_t  state_q;
	logic        stack_q [STACK_DEPTH];

	// result register
	logic        out_valid_q;
	jst_result_t res_q;

	jst_state_t  state_nxt;
	jst_result_t step_res;
	logic        push_en;
	logic        push_val;
	logic        pop_mode;
	logic [SP_W-1:0] sp_m2;
	logic        adv;

	// advance the held request whenever the result register is free or being drained
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload needs no reset; load it with each accepted request
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1  <= cmd;
			byte_s1 <= in_byte;
		end
	end

	// a pop exposes the entry two below the pointer: the new top of stack
	assign sp_m2    = state_q.sp - SP_W'(2);
	assign pop_mode = stack_q[sp_m2[STK_IDX_W-1:0]];

	jst_step u_step (
		.cur      (state_q),
		.cmd      (cmd_s1),
		.in_byte  (byte_s1),
		.pop_mode (pop_mode),
		.nxt      (state_nxt),
		.push_en  (push_en),
		.push_val (push_val),
		.res      (step_res)
	);

	// commit the scanner state only when the request moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= JST_RESET;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	// the stack pointer stays below the depth, so its low bits address every entry
	always_ff @(posedge clk) begin
		if (adv && push_en) begin
			stack_q[state_q.sp[STK_IDX_W-1:0]] <= push_val;
		end
	end

	// result register: hold until taken, refill in the same cycle it drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= step_res;
		end
	end

	assign out_valid     = out_valid_q;
	assign char_kind     = res_q.kind;
	assign char_out      = res_q.chr;
	assign char_index    = res_q.idx;
	assign value_commit  = res_q.commit;
	assign object_opened = res_q.oopen;
	assign array_opened  = res_q.aopen;
	assign level_closed  = res_q.closed;
	assign item_pushed   = res_q.pushed;
	assign nest_depth    = res_q.depth;
	assign error_code    = res_q.err;
	assign doc_done      = res_q.done;

	// the push guards keep both levels inside the stack, the text guard inside the buffer
	`JST_ASSERT_ALWAYS(a_sp_bound, state_q.sp <= SP_LIMIT)
	`JST_ASSERT_ALWAYS(a_depth_bound, state_q.depth <= DEP_LIMIT)
	`JST_ASSERT_ALWAYS(a_text_bound, state_q.tlen <= TXT_LIMIT)
	// a latched error survives every byte until the document ends
	`JST_ASSERT_NEXT(a_err_sticky, (state_q.err != ERR_NONE) && !step_res.done, $stable(state_q.err))

endmodule
